// ----- hw/rtl/tlpu_pkg.sv -----
// Shared types, constants and widths for the tree leaf posterior update block.
// Used by every module under hw/rtl but tlpu_fifo; depends on nothing else.
package tlpu_pkg;

   localparam int MaxNodesDefault = 64;
   localparam int CountWidth      = 20;
   localparam int SumWidth        = 52;
   localparam int WeightWidth     = 20;
   localparam int DataWidth       = 32;
   localparam int LabelWidth      = 7;
   localparam int RowWidth        = 6;
   localparam int CsrIndexWidth   = 2;
   // Numerator of the mean is Q.24 and needs 52+8+1 bits; divider works on 62 bits.
   localparam int NumWidth        = 62;
   // Denominator count*256 + a fits in 29 bits.
   localparam int DenWidth        = 29;
   localparam int QueueDepth      = 4;

   localparam logic [CountWidth-1:0] CountMax = '1;
   localparam logic [WeightWidth-1:0] PriorWeightReset = 20'd256;
   localparam logic [DataWidth-1:0] NoiseVarianceReset = 32'd65536;
   localparam logic [DataWidth-1:0] PriorMeanReset = 32'd0;

   typedef enum logic [1:0] {
      CMD_ROW    = 2'd0,
      CMD_CELL   = 2'd1,
      CMD_FINISH = 2'd2,
      CMD_NONE   = 2'd3
   } command_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_PRIOR_WEIGHT   = 2'd0,
      CSR_NOISE_VARIANCE = 2'd1,
      CSR_PRIOR_MEAN     = 2'd2,
      CSR_UNUSED         = 2'd3
   } csr_index_type;

   // Word passed from the front end to the back end through the queue.
   typedef struct packed {
      command_type             command;
      logic [RowWidth-1:0]     row_index;
      logic                    is_terminal;
      logic [LabelWidth-1:0]   node_label;
      logic [DataWidth-1:0]    residual;
   } work_type;

   // Result word held in the output queue.
   typedef struct packed {
      logic [LabelWidth-1:0]   node_number;
      logic [DataWidth-1:0]    posterior_mean;
      logic [DataWidth-1:0]    posterior_variance;
      logic [CountWidth-1:0]   obs_count;
      logic                    last;
   } result_type;

endpackage

// ----- hw/rtl/tlpu_fifo.sv -----
// Small register queue used between the front end and back end and on the result side.
// Does not use tlpu_pkg; the parent hands in the word width.
module tlpu_fifo #(
   parameter int Depth = 4,
   parameter int Width = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [Width-1:0] pop_data,
   output logic             empty
);
   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;

   logic [Width-1:0]    entry_ff [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PtrWidth:0]   fill_ff, fill_in;
   logic                do_push, do_pop;

   assign full     = (fill_ff == (PtrWidth+1)'(Depth));
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      fill_in = fill_ff + (PtrWidth+1)'(do_push) - (PtrWidth+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// ----- hw/rtl/tlpu_divider.sv -----
// Restoring radix-2 divider, one quotient bit per cycle, with rounding to nearest.
// Depends on tlpu_pkg for the operand widths.
module tlpu_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tlpu_pkg::NumWidth-1:0] dividend,
   input  logic [tlpu_pkg::DenWidth-1:0] divisor,
   output logic                          done,
   output logic [tlpu_pkg::NumWidth-1:0] quotient
);
   localparam int NW = tlpu_pkg::NumWidth;
   localparam int DW = tlpu_pkg::DenWidth;
   localparam int StepWidth = $clog2(NW + 1);

   logic [NW-1:0]        quo_ff, quo_in;
   logic [DW:0]          rem_ff, rem_in;
   logic [DW-1:0]        div_ff, div_in;
   logic [StepWidth-1:0] step_ff, step_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [DW+1:0]        trial;

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         // Rounding is folded in: the dividend carries den/2 already.
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         step_in = StepWidth'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff, quo_ff[NW-1]} - {2'b00, div_ff};
         if (!trial[DW+1]) begin
            rem_in = trial[DW:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DW-1:0], quo_ff[NW-1]};
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == StepWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end
endmodule

// ----- hw/rtl/tlpu_back.sv -----
// Back end: node accumulators, terminal marks and the finish walk that emits results.
// Depends on tlpu_pkg, tlpu_divider.
module tlpu_back #(
   parameter int MaxNodes = tlpu_pkg::MaxNodesDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               work_valid,
   input  tlpu_pkg::work_type                 work_word,
   output logic                               work_pop,
   input  logic [tlpu_pkg::WeightWidth-1:0]   prior_weight,
   input  logic [tlpu_pkg::DataWidth-1:0]     noise_variance,
   input  logic [tlpu_pkg::DataWidth-1:0]     prior_mean,
   output logic                               result_push,
   output tlpu_pkg::result_type               result_word,
   input  logic                               result_full,
   output logic                               idle
);
   localparam int NodeWidth = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;
   localparam int NW = tlpu_pkg::NumWidth;
   localparam int DW = tlpu_pkg::DenWidth;
   localparam int SW = tlpu_pkg::SumWidth;
   localparam int CW = tlpu_pkg::CountWidth;

   typedef enum logic [3:0] {
      ST_RUN, ST_ACC, ST_SCAN, ST_READ, ST_MAG, ST_START, ST_MEAN, ST_VAR, ST_EMIT,
      ST_CLEAR
   } state_type;

   state_type            state_ff;
   logic [MaxNodes-1:0]  mark_ff;
   logic [MaxNodes-1:0]  touched_ff;
   logic [SW-1:0]        sum_mem [MaxNodes];
   logic [CW-1:0]        cnt_mem [MaxNodes];
   logic [SW-1:0]        mem_sum_ff;
   logic [CW-1:0]        mem_cnt_ff;
   logic                 mem_hit_ff;
   logic [NodeWidth-1:0] node_ff;
   logic [SW-1:0]        rd_sum_ff;
   logic [CW-1:0]        rd_cnt_ff;
   logic [NodeWidth-1:0] rd_addr;
   logic [NodeWidth-1:0] acc_addr_ff;
   logic [tlpu_pkg::DataWidth-1:0] acc_res_ff;
   logic                 acc_write;
   logic [SW-1:0]        acc_sum;
   logic [CW-1:0]        acc_cnt;
   logic [DW-1:0]        den_ff;
   logic                 neg_ff;
   logic [NW-1:0]        num_mag_ff;
   logic [NW-1:0]        div_dividend;
   logic                 div_start;
   logic                 div_done;
   logic [NW-1:0]        div_quotient;
   logic [tlpu_pkg::DataWidth-1:0] mean_ff;
   logic [tlpu_pkg::DataWidth-1:0] var_ff;
   logic [MaxNodes-1:0]  remaining;
   logic                 more_after;
   logic signed [52:0]   wmu_ff;
   logic                 cell_hit;
   logic [NodeWidth-1:0] cell_addr;
   logic [SW-1:0]        cur_sum;
   logic [CW-1:0]        cur_cnt;
   logic signed [NW-1:0] num_s;
   logic [NW-1:0]        half_den;
   logic [6:0]           lbl;

   assign lbl       = work_word.node_label;
   assign cell_hit  = (lbl != '0) && ({1'b0, lbl} <= 8'(MaxNodes));
   assign cell_addr = NodeWidth'(lbl - 7'd1);
   assign rd_addr   = (state_ff == ST_RUN) ? cell_addr : node_ff;
   // Memory reads are registered: the entry addressed in one cycle is used in the next.
   // An entry not written since the last clear reads as zero.
   assign cur_sum   = mem_hit_ff ? mem_sum_ff : '0;
   assign cur_cnt   = mem_hit_ff ? mem_cnt_ff : '0;
   assign acc_write = (state_ff == ST_ACC) && (cur_cnt != tlpu_pkg::CountMax);
   assign acc_sum   = cur_sum + SW'($signed(acc_res_ff));
   assign acc_cnt   = cur_cnt + 1'b1;
   assign work_pop  = (state_ff == ST_RUN) && work_valid;
   assign idle      = (state_ff == ST_RUN);
   assign remaining = mark_ff & ~((MaxNodes)'(1) << node_ff) &
                      ~(((MaxNodes)'(1) << node_ff) - (MaxNodes)'(1));
   assign more_after = (remaining != '0);
   assign num_s     = NW'($signed({rd_sum_ff, 8'd0})) + NW'(wmu_ff);
   assign half_den  = NW'(den_ff >> 1);
   assign div_dividend = (state_ff == ST_START)
                       ? (num_mag_ff + half_den)
                       : (NW'({noise_variance, 8'd0}) + half_den);
   assign div_start = (state_ff == ST_START)
                   || (state_ff == ST_MEAN && div_done);

   tlpu_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(den_ff), .done(div_done), .quotient(div_quotient)
   );

   always_comb begin
      result_word.node_number        = 7'(node_ff) + 7'd1;
      result_word.posterior_mean     = mean_ff;
      result_word.posterior_variance = var_ff;
      result_word.obs_count          = rd_cnt_ff;
      result_word.last               = !more_after;
   end
   assign result_push = (state_ff == ST_EMIT) && !result_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         mark_ff       <= '0;
         touched_ff    <= '0;
         node_ff       <= '0;
      end else begin
         case (state_ff)
            ST_RUN: begin
               if (work_valid) begin
                  case (work_word.command)
                     tlpu_pkg::CMD_ROW: begin
                        if (32'(work_word.row_index) < MaxNodes) begin
                           mark_ff[NodeWidth'(work_word.row_index)] <= work_word.is_terminal;
                        end
                     end
                     tlpu_pkg::CMD_CELL: begin
                        if (cell_hit) begin
                           acc_addr_ff <= cell_addr;
                           acc_res_ff  <= work_word.residual;
                           state_ff    <= ST_ACC;
                        end
                     end
                     tlpu_pkg::CMD_FINISH: begin
                        node_ff  <= '0;
                        state_ff <= ST_SCAN;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_ACC: begin
               if (acc_write) begin
                  touched_ff[acc_addr_ff] <= 1'b1;
               end
               state_ff <= ST_RUN;
            end
            ST_SCAN: begin
               if (mark_ff[node_ff]) begin
                  state_ff <= ST_READ;
               end else if (node_ff == NodeWidth'(MaxNodes-1)) begin
                  state_ff <= ST_CLEAR;
               end else begin
                  node_ff <= node_ff + 1'b1;
               end
            end
            ST_READ: begin
               rd_sum_ff <= cur_sum;
               rd_cnt_ff <= cur_cnt;
               den_ff    <= DW'({cur_cnt, 8'd0}) + DW'(prior_weight);
               wmu_ff    <= $signed({1'b0, prior_weight}) * $signed(prior_mean);
               state_ff  <= ST_MAG;
            end
            ST_MAG: begin
               neg_ff     <= num_s[NW-1];
               num_mag_ff <= num_s[NW-1] ? NW'(-num_s) : NW'(num_s);
               state_ff   <= ST_START;
            end
            ST_START: begin
               state_ff <= ST_MEAN;
            end
            ST_MEAN: begin
               if (div_done) begin
                  if (den_ff == '0) begin
                     mean_ff <= '0;
                  end else if (!neg_ff) begin
                     mean_ff <= (div_quotient > NW'(32'h7FFFFFFF))
                              ? 32'h7FFFFFFF : div_quotient[31:0];
                  end else begin
                     mean_ff <= (div_quotient > NW'(33'h080000000))
                              ? 32'h80000000 : 32'(-div_quotient[31:0]);
                  end
                  state_ff <= ST_VAR;
               end
            end
            ST_VAR: begin
               if (div_done) begin
                  if (den_ff == '0 || div_quotient > NW'(32'hFFFFFFFF)) begin
                     var_ff <= '1;
                  end else begin
                     var_ff <= div_quotient[31:0];
                  end
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (!result_full) begin
                  if (!more_after) begin
                     state_ff <= ST_CLEAR;
                  end else begin
                     node_ff  <= node_ff + 1'b1;
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_CLEAR: begin
               mark_ff    <= '0;
               touched_ff <= '0;
               state_ff   <= ST_RUN;
            end
            default: state_ff <= ST_RUN;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (acc_write) begin
         sum_mem[acc_addr_ff] <= acc_sum;
         cnt_mem[acc_addr_ff] <= acc_cnt;
      end
      mem_sum_ff <= sum_mem[rd_addr];
      mem_cnt_ff <= cnt_mem[rd_addr];
      mem_hit_ff <= touched_ff[rd_addr];
   end
endmodule

// ----- hw/rtl/tree_leaf_posterior_update.sv -----
// Tree leaf posterior update: top level with config registers, queues and back end.
// Depends on tlpu_pkg, tlpu_fifo, tlpu_back.
//
// Tree rows set or clear their node's terminal mark in the back end; for an observation
// cell the node's entry is read, then the updated sum and count are written back. A
// finish word walks the nodes in order. For each terminal node the entry is fetched and
// the numerator formed, the mean and then the variance quotient are computed in the
// shared one-bit-per-cycle divider, and the result is emitted once the result queue has
// room. Nodes past the last terminal one are skipped, and then the marks are cleared.
// Words arriving during the walk wait in a four-entry queue. No clearing pass is needed
// after reset.
module tree_leaf_posterior_update #(
   parameter int MaxNodes = tlpu_pkg::MaxNodesDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic [1:0]                          req_command,
   input  logic [tlpu_pkg::RowWidth-1:0]       req_row_index,
   input  logic                                req_is_terminal,
   input  logic [tlpu_pkg::LabelWidth-1:0]     req_node_label,
   input  logic signed [tlpu_pkg::DataWidth-1:0] req_residual,
   output logic                                empty,
   input  logic                                pop,
   output logic [tlpu_pkg::LabelWidth-1:0]     rsp_node_number,
   output logic signed [tlpu_pkg::DataWidth-1:0] rsp_posterior_mean,
   output logic [tlpu_pkg::DataWidth-1:0]      rsp_posterior_variance,
   output logic [tlpu_pkg::CountWidth-1:0]     rsp_obs_count,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tlpu_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [tlpu_pkg::DataWidth-1:0]      csr_data
);
   localparam int WorkWidth   = $bits(tlpu_pkg::work_type);
   localparam int ResultWidth = $bits(tlpu_pkg::result_type);

   logic [tlpu_pkg::WeightWidth-1:0] prior_weight_ff;
   logic [tlpu_pkg::DataWidth-1:0]   noise_variance_ff;
   logic [tlpu_pkg::DataWidth-1:0]   prior_mean_ff;
   tlpu_pkg::work_type               in_word, work_word;
   logic [WorkWidth-1:0]             work_bits;
   logic                             work_empty, work_pop;
   tlpu_pkg::result_type             result_word, out_word;
   logic [ResultWidth-1:0]           out_bits;
   logic                             result_push, result_full, back_idle;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prior_weight_ff   <= tlpu_pkg::PriorWeightReset;
         noise_variance_ff <= tlpu_pkg::NoiseVarianceReset;
         prior_mean_ff     <= tlpu_pkg::PriorMeanReset;
      end else if (csr_valid) begin
         case (tlpu_pkg::csr_index_type'(csr_index))
            tlpu_pkg::CSR_PRIOR_WEIGHT:   prior_weight_ff <= csr_data[tlpu_pkg::WeightWidth-1:0];
            tlpu_pkg::CSR_NOISE_VARIANCE: noise_variance_ff <= csr_data;
            tlpu_pkg::CSR_PRIOR_MEAN:     prior_mean_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      in_word.command     = tlpu_pkg::command_type'(req_command);
      in_word.row_index   = req_row_index;
      in_word.is_terminal = req_is_terminal;
      in_word.node_label  = req_node_label;
      in_word.residual    = req_residual;
   end

   tlpu_fifo #(.Depth(tlpu_pkg::QueueDepth), .Width(WorkWidth)) u_work_q (
      .clock(clock), .reset(reset), .push(push), .push_data(in_word), .full(full),
      .pop(work_pop), .pop_data(work_bits), .empty(work_empty)
   );
   assign work_word = tlpu_pkg::work_type'(work_bits);

   tlpu_back #(.MaxNodes(MaxNodes)) u_back (
      .clock(clock), .reset(reset), .work_valid(!work_empty), .work_word(work_word),
      .work_pop(work_pop), .prior_weight(prior_weight_ff),
      .noise_variance(noise_variance_ff), .prior_mean(prior_mean_ff),
      .result_push(result_push), .result_word(result_word), .result_full(result_full),
      .idle(back_idle)
   );

   tlpu_fifo #(.Depth(tlpu_pkg::QueueDepth), .Width(ResultWidth)) u_result_q (
      .clock(clock), .reset(reset), .push(result_push), .push_data(result_word),
      .full(result_full), .pop(pop), .pop_data(out_bits), .empty(empty)
   );
   assign out_word               = tlpu_pkg::result_type'(out_bits);
   assign rsp_node_number        = out_word.node_number;
   assign rsp_posterior_mean     = out_word.posterior_mean;
   assign rsp_posterior_variance = out_word.posterior_variance;
   assign rsp_obs_count          = out_word.obs_count;
   assign rsp_last               = out_word.last;

   // A result word is only produced while the back end is busy with a walk.
   a_push_not_idle: assert property (@(posedge clock) disable iff (reset)
      result_push |-> !back_idle) else $error("result produced while back end idle");
   // The back end never pushes into a full result queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      result_push |-> !result_full) else $error("result queue overflow");
   // Node numbers shown on the result side are never zero.
   a_node_nonzero: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_node_number != '0) else $error("zero node number on output");
endmodule
